// ===== rtl/qpd_pkg.sv =====
// Shared types, character codes and helper functions for the quoted-printable decoder.
// Used by qpd_out_queue and quoted_printable_decoder_core; no dependencies.
package qpd_pkg;

	// Width of the depth limit register.
	localparam int LIMIT_W = 17;
	// Default saturation point of the output count.
	localparam int MAX_PART_BYTES_DEF = 65536;
	// Most results that one encoded byte can cause.
	localparam int RES_MAX = 3;
	localparam int RES_N_W = 2;
	// Output queue: power-of-two depth, room for one full burst plus one word.
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QLVL_W  = 3;

	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LFH = 8'h66;

	// One decoded word as it waits in the output queue.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       depth;
	} qpd_res_t;

	// Words produced by one accepted byte, lowest index first.
	typedef struct packed {
		logic [RES_N_W-1:0]        n;
		qpd_res_t [RES_MAX-1:0]    ent;
	} qpd_push_t;

	// Bytes that pass through as plain text.
	function automatic logic is_plain(input logic [7:0] c);
		is_plain = (c >= CH_SP && c < CH_DEL) || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	// Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		hex_nib = 5'h00;
		if (c >= CH_0 && c <= CH_9) begin
			d = c - CH_0;
			hex_nib = {1'b1, d[3:0]};
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - CH_UA + 8'd10;
			hex_nib = {1'b1, d[3:0]};
		end else if (c >= CH_LA && c <= CH_LFH) begin
			d = c - CH_LA + 8'd10;
			hex_nib = {1'b1, d[3:0]};
		end
	endfunction

endpackage

// ===== rtl/qpd_out_queue.sv =====
// Output queue for decoded words: up to three in per cycle, one out per ready cycle.
// Depends on qpd_pkg for the word and burst types and the queue geometry.
module qpd_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  qpd_pkg::qpd_push_t push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output qpd_pkg::qpd_res_t  out_ent
);

	qpd_pkg::qpd_res_t                 slot_q [qpd_pkg::QDEPTH];
	logic [qpd_pkg::QPTR_W-1:0]        wr_q;
	logic [qpd_pkg::QPTR_W-1:0]        rd_q;
	logic [qpd_pkg::QLVL_W-1:0]        level_q;
	logic                              pop;

	assign out_valid = level_q != '0;
	assign out_ent   = slot_q[rd_q];
	assign pop       = out_valid && out_ready;
	// Enough space for a full burst, ignoring any pop this cycle.
	assign room      = level_q <= qpd_pkg::QLVL_W'(qpd_pkg::QDEPTH - qpd_pkg::RES_MAX);

	always_ff @(posedge clk) begin
		for (int i = 0; i < qpd_pkg::RES_MAX; i++) begin
			if (qpd_pkg::RES_N_W'(i) < push.n) begin
				slot_q[wr_q + qpd_pkg::QPTR_W'(i)] <= push.ent[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + qpd_pkg::QPTR_W'(push.n);
			rd_q    <= rd_q + qpd_pkg::QPTR_W'(pop);
			level_q <= level_q + qpd_pkg::QLVL_W'(push.n) - qpd_pkg::QLVL_W'(pop);
		end
	end

endmodule

// ===== rtl/quoted_printable_decoder_core.sv =====
// Quoted-printable decoder core: stream in, stream out, one depth limit register.
// Depends on qpd_pkg and instantiates qpd_out_queue.
//
// Takes one encoded byte per cycle while s_tready is high, decodes it in the cycle
// it is accepted, and its words can appear on the master side from the next cycle.
// Printable bytes, tab, CR and LF pass through; other bytes but "=" are dropped.
// "=" followed by LF or CR LF is a soft line break; "=" and two hex digits give the
// decoded byte; any other escape passes the "=" and re-handles the two following
// bytes, so one input byte can give one, two or three words. Words leave at one per
// ready cycle from a four-word queue, and the slave side is ready whenever the queue
// holds at most one word, so with an always-ready master the block sustains one byte
// per cycle while each byte gives at most one word; larger bursts stall the input.
// tuser on the slave side marks the first byte of a new part and clears escape state
// and the output count before that byte. With a nonzero depth_limit the word that
// brings the count to the limit carries tuser high on the master side, and all later
// bytes of the part are swallowed until the next new part. Write the limit only
// while the block is idle.
module quoted_printable_decoder_core #(
	parameter int MAX_PART_BYTES = qpd_pkg::MAX_PART_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// slave side
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] data_byte
	input  logic                        s_tuser,   // [0] new_part
	// master side
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,   // [7:0] out_byte
	output logic                        m_tlast,   // last word caused by one input byte
	output logic                        m_tuser,   // [0] depth_reached
	// depth limit register
	input  logic                        cfg_we,
	input  logic [qpd_pkg::LIMIT_W-1:0] cfg_wdata
);

	// Count width holds MAX_PART_BYTES; arithmetic width also covers the limit.
	localparam int CNT_W = $clog2(MAX_PART_BYTES + 1);
	localparam int CW    = (CNT_W > qpd_pkg::LIMIT_W) ? CNT_W : qpd_pkg::LIMIT_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_PART_BYTES);

	// Escape phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;  // no escape pending
	localparam logic [1:0] PH_EQ   = 2'd1;  // "=" seen
	localparam logic [1:0] PH_HELD = 2'd2;  // "=" and one byte seen

	logic [1:0]                  phase_q;
	logic [7:0]                  held_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [qpd_pkg::LIMIT_W-1:0] limit_q;

	logic                        accept;
	logic                        room;
	logic [7:0]                  b;
	logic [1:0]                  ph;
	logic [7:0]                  held;
	logic [CW-1:0]               cnt;
	logic [CW-1:0]               lim;
	logic [CW-1:0]               rem;
	logic                        halted;
	logic [4:0]                  hx1;
	logic [4:0]                  hx2;
	logic [1:0]                  m;
	logic [7:0]                  e0;
	logic [7:0]                  e1;
	logic [7:0]                  e2;
	logic [1:0]                  n;
	logic [1:0]                  ph_n;
	logic [7:0]                  held_n;
	logic [CW:0]                 cnt_sum;
	logic [CW-1:0]               cnt_n;
	qpd_pkg::qpd_push_t          push;
	qpd_pkg::qpd_res_t           out_ent;

	assign s_tready = room;
	assign accept   = s_tvalid && room;
	assign b        = s_tdata;

	always_comb begin
		// Apply a new part's clear before the byte.
		ph   = s_tuser ? PH_IDLE : phase_q;
		held = s_tuser ? 8'h00 : held_q;
		cnt  = s_tuser ? '0 : CW'(cnt_q);

		lim    = (CW'(limit_q) > MAX_C) ? MAX_C : CW'(limit_q);
		halted = (lim != '0) && (cnt >= lim);
		rem    = lim - cnt;

		hx1 = qpd_pkg::hex_nib(held);
		hx2 = qpd_pkg::hex_nib(b);

		// Candidate words in order, before the depth limit.
		ph_n   = PH_IDLE;
		held_n = held;
		m      = 2'd0;
		e0     = b;
		e1     = b;
		e2     = b;
		case (ph)
			PH_EQ: begin
				if (b != qpd_pkg::CH_LF) begin
					held_n = b;
					ph_n   = PH_HELD;
				end
			end
			PH_HELD: begin
				if (held == qpd_pkg::CH_CR && b == qpd_pkg::CH_LF) begin
					ph_n = PH_IDLE;
				end else if (hx1[4] && hx2[4]) begin
					m  = 2'd1;
					e0 = {hx1[3:0], hx2[3:0]};
				end else begin
					// Broken escape: pass the "=", replay both bytes.
					m  = 2'd1;
					e0 = qpd_pkg::CH_EQ;
					if (held == qpd_pkg::CH_EQ) begin
						if (b != qpd_pkg::CH_LF) begin
							held_n = b;
							ph_n   = PH_HELD;
						end
					end else begin
						if (qpd_pkg::is_plain(held)) begin
							m  = 2'd2;
							e1 = held;
						end
						if (b == qpd_pkg::CH_EQ) begin
							ph_n = PH_EQ;
						end else if (qpd_pkg::is_plain(b)) begin
							if (m == 2'd2) begin
								m  = 2'd3;
								e2 = b;
							end else begin
								m  = 2'd2;
								e1 = b;
							end
						end
					end
				end
			end
			default: begin
				if (b == qpd_pkg::CH_EQ) begin
					ph_n = PH_EQ;
				end else if (qpd_pkg::is_plain(b)) begin
					m  = 2'd1;
					e0 = b;
				end
			end
		endcase

		// Trim the burst at the limit.
		if (lim == '0) begin
			n = m;
		end else if (halted) begin
			n = 2'd0;
		end else if (rem < CW'(m)) begin
			n = rem[1:0];
		end else begin
			n = m;
		end

		cnt_sum = {1'b0, cnt} + (CW + 1)'(n);
		cnt_n   = (cnt_sum > {1'b0, MAX_C}) ? MAX_C : cnt_sum[CW-1:0];

		// A part at its limit swallows the byte and keeps its state.
		if (halted) begin
			ph_n   = ph;
			held_n = held;
		end

		push.n            = accept ? n : 2'd0;
		push.ent[0].data  = e0;
		push.ent[1].data  = e1;
		push.ent[2].data  = e2;
		for (int i = 0; i < qpd_pkg::RES_MAX; i++) begin
			push.ent[i].last  = (n == qpd_pkg::RES_N_W'(i + 1));
			push.ent[i].depth = (lim != '0) && (rem == CW'(i + 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'h00;
			cnt_q   <= '0;
			limit_q <= '0;
		end else begin
			if (accept) begin
				phase_q <= ph_n;
				held_q  <= held_n;
				cnt_q   <= cnt_n[CNT_W-1:0];
			end
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
		end
	end

	qpd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ent   (out_ent)
	);

	assign m_tdata = out_ent.data;
	assign m_tlast = out_ent.last;
	assign m_tuser = out_ent.depth;

endmodule

// ===== tb/sv/qpd_stream_checker.sv =====
// Scoreboard for the quoted-printable decoder core: watches the byte, word and limit ports.
// Keeps its own decoder state and a queue of expected words. Depends on qpd_pkg.
module qpd_stream_checker #(
	parameter int PART_MAX = qpd_pkg::MAX_PART_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [7:0]                  s_tdata,
	input  logic                        s_tuser,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [7:0]                  m_tdata,
	input  logic                        m_tlast,
	input  logic                        m_tuser,
	input  logic                        cfg_we,
	input  logic [qpd_pkg::LIMIT_W-1:0] cfg_wdata,
	output int                          errors,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {ESC_NONE, ESC_EQ, ESC_HELD} esc_t;

	logic [qpd_pkg::LIMIT_W-1:0] limit_reg;
	esc_t                        esc;
	logic [7:0]                  held;
	int                          count;
	qpd_pkg::qpd_res_t           expected_words[$];
	qpd_pkg::qpd_res_t           step_words[$];

	// Limit register values above the part size act as the part size.
	function automatic int cap();
		if (int'(limit_reg) > PART_MAX)
			return PART_MAX;
		return int'(limit_reg);
	endfunction

	function automatic bit halted();
		return cap() != 0 && count >= cap();
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= qpd_pkg::CH_0 && c <= qpd_pkg::CH_9)
			return int'(c - qpd_pkg::CH_0);
		if (c >= qpd_pkg::CH_UA && c <= qpd_pkg::CH_UF)
			return int'(c - qpd_pkg::CH_UA) + 10;
		if (c >= qpd_pkg::CH_LA && c <= qpd_pkg::CH_LFH)
			return int'(c - qpd_pkg::CH_LA) + 10;
		return -1;
	endfunction

	task automatic emit(input logic [7:0] v);
		qpd_pkg::qpd_res_t w;
		if (halted() || step_words.size() >= qpd_pkg::RES_MAX)
			return;
		if (count < PART_MAX)
			count++;
		w.data  = v;
		w.last  = 1'b0;
		w.depth = (cap() != 0 && count == cap());
		step_words.push_back(w);
	endtask

	task automatic take_plain(input logic [7:0] b);
		if (b == qpd_pkg::CH_EQ)
			esc = ESC_EQ;
		else if ((b >= qpd_pkg::CH_SP && b < qpd_pkg::CH_DEL) || b == qpd_pkg::CH_TAB
			|| b == qpd_pkg::CH_CR || b == qpd_pkg::CH_LF)
			emit(b);
	endtask

	// Hold the byte after "=", or drop the escape on a soft break with LF alone.
	task automatic hold_or_break(input logic [7:0] b);
		if (b == qpd_pkg::CH_LF) begin
			esc = ESC_NONE;
		end else begin
			held = b;
			esc  = ESC_HELD;
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic new_part);
		logic [7:0] c1;
		int         h1;
		int         h2;
		if (new_part) begin
			esc   = ESC_NONE;
			held  = 8'h00;
			count = 0;
		end
		if (halted())
			return;
		step_words.delete();
		case (esc)
			ESC_EQ: begin
				hold_or_break(b);
			end
			ESC_HELD: begin
				c1  = held;
				esc = ESC_NONE;
				h1  = hex_digit(c1);
				h2  = hex_digit(b);
				if (c1 == qpd_pkg::CH_CR && b == qpd_pkg::CH_LF) begin
					// soft line break, nothing to pass on
				end else if (h1 >= 0 && h2 >= 0) begin
					emit({h1[3:0], h2[3:0]});
				end else begin
					emit(qpd_pkg::CH_EQ);
					take_plain(c1);
					if (esc == ESC_EQ)
						hold_or_break(b);
					else
						take_plain(b);
				end
			end
			default: begin
				esc = ESC_NONE;
				take_plain(b);
			end
		endcase
		if (step_words.size() > 0)
			step_words[step_words.size() - 1].last = 1'b1;
		foreach (step_words[i])
			expected_words.push_back(step_words[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		qpd_pkg::qpd_res_t w;
		if (!arst_n) begin
			limit_reg = '0;
			esc       = ESC_NONE;
			held      = 8'h00;
			count     = 0;
			expected_words.delete();
			errors    = 0;
			pending   = 0;
		end else begin
			// Words leave in the cycle after their byte at the earliest: check, then predict.
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$display("%0t ns: unexpected word, expected none, ", $time,
						"actual data=%02h last=%b depth=%b", m_tdata, m_tlast, m_tuser);
					errors++;
				end else begin
					w = expected_words.pop_front();
					if (m_tdata !== w.data || m_tlast !== w.last || m_tuser !== w.depth) begin
						$display("%0t ns: word mismatch, ", $time,
							"expected data=%02h last=%b depth=%b, ",
							w.data, w.last, w.depth,
							"actual data=%02h last=%b depth=%b",
							m_tdata, m_tlast, m_tuser);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tuser);
			if (cfg_we)
				limit_reg = cfg_wdata;
			pending = expected_words.size();
		end
	end

endmodule

// ===== tb/sv/tb_quoted_printable_decoder_core.sv =====
// Top of the quoted-printable decoder testbench: clock, reset, byte stimulus and verdict.
// Instantiates quoted_printable_decoder_core and qpd_stream_checker; uses qpd_pkg.
module tb_quoted_printable_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	// A small part size, so that limit clamping is reachable.
	localparam int PART_MAX     = 256;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 60;
	localparam int SETTLE       = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_BYTES  = 55;
	localparam int SHORT_PART   = 5;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [7:0]                  s_tdata = 8'h00;
	logic                        s_tuser = 1'b0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [7:0]                  m_tdata;
	logic                        m_tlast;
	logic                        m_tuser;
	logic                        cfg_we = 1'b0;
	logic [qpd_pkg::LIMIT_W-1:0] cfg_wdata = '0;

	int errors;
	int pending;
	int cycles     = 0;
	int sent_bytes = 0;
	// Idle percentages of the two sides, changed per phase.
	int send_idle  = 16;
	int recv_idle  = 86;
	// Bump stall_tag to make the receiver hold off for HOLD_CYCLES.
	int stall_tag  = 0;
	int stall_seen = 0;
	int stall_left = 0;

	quoted_printable_decoder_core #(
		.MAX_PART_BYTES(PART_MAX)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	qpd_stream_checker #(
		.PART_MAX(PART_MAX)
	) i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: give up on a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus a long hold-off whenever stall_tag moves.
	initial begin
		forever begin
			@(negedge clk);
			if (stall_tag != stall_seen) begin
				stall_seen = stall_tag;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	// Offer one byte on the slave side; enter and leave at a falling edge.
	task automatic offer_byte(input logic [7:0] b, input logic new_part);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= new_part;
		do
			@(posedge clk);
		while (!s_tready);
		sent_bytes++;
		@(negedge clk);
	endtask

	// Drop valid and hold until every expected word is out and the core has settled.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_limit(input logic [qpd_pkg::LIMIT_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return qpd_pkg::CH_0 + 8'(v);
		return ($urandom_range(0, 1) ? qpd_pkg::CH_UA : qpd_pkg::CH_LA) + 8'(v - 10);
	endfunction

	// One random encoded token: mostly well-formed escapes and text, some noise.
	task automatic offer_token(input bit allow_part);
		int         pick;
		logic       np;
		logic       np_mid;
		logic [7:0] ws;
		pick   = $urandom_range(0, 99);
		np     = allow_part && ($urandom_range(0, 99) < 6);
		np_mid = allow_part && ($urandom_range(0, 99) < 3);
		ws     = ($urandom_range(0, 2) == 0) ? qpd_pkg::CH_TAB
			: ($urandom_range(0, 1) ? qpd_pkg::CH_CR : qpd_pkg::CH_LF);
		if (pick < 40) begin
			offer_byte(8'($urandom_range(qpd_pkg::CH_SP, qpd_pkg::CH_DEL - 1)), np);
		end else if (pick < 60) begin
			offer_byte(qpd_pkg::CH_EQ, np);
			offer_byte(hex_char(), np_mid);
			offer_byte(hex_char(), 1'b0);
		end else if (pick < 68) begin
			offer_byte(qpd_pkg::CH_EQ, np);
			offer_byte(qpd_pkg::CH_LF, 1'b0);
		end else if (pick < 74) begin
			offer_byte(qpd_pkg::CH_EQ, np);
			offer_byte(qpd_pkg::CH_CR, 1'b0);
			offer_byte(qpd_pkg::CH_LF, 1'b0);
		end else if (pick < 84) begin
			// broken escape, re-handles both following bytes
			offer_byte(qpd_pkg::CH_EQ, np);
			offer_byte(8'($urandom_range(0, 255)), np_mid);
			offer_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (pick < 90) begin
			offer_byte(ws, np);
		end else begin
			offer_byte(8'($urandom_range(0, 255)), np);
		end
	endtask

	task automatic random_phase(input int n_bytes, input bit allow_part);
		int stop_at;
		stop_at = sent_bytes + n_bytes;
		while (sent_bytes < stop_at)
			offer_token(allow_part);
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed, unlimited: plain bytes at the edges, each escape form.
		offer_byte(8'h41, 1'b1);
		offer_byte(8'h00, 1'b0);                  // dropped
		offer_byte(8'hFF, 1'b0);                  // dropped
		offer_byte(qpd_pkg::CH_DEL, 1'b0);        // dropped
		offer_byte(8'h7E, 1'b0);
		offer_byte(qpd_pkg::CH_SP, 1'b0);
		offer_byte(qpd_pkg::CH_TAB, 1'b0);
		offer_byte(qpd_pkg::CH_CR, 1'b0);
		offer_byte(qpd_pkg::CH_LF, 1'b0);
		offer_byte(qpd_pkg::CH_EQ, 1'b0);         // "=3D"
		offer_byte(8'h33, 1'b0);
		offer_byte(8'h44, 1'b0);
		offer_byte(qpd_pkg::CH_EQ, 1'b0);         // "=fF", mixed case
		offer_byte(8'h66, 1'b0);
		offer_byte(8'h46, 1'b0);
		offer_byte(qpd_pkg::CH_EQ, 1'b0);         // soft break, LF alone
		offer_byte(qpd_pkg::CH_LF, 1'b0);
		offer_byte(qpd_pkg::CH_EQ, 1'b0);         // soft break, CR LF
		offer_byte(qpd_pkg::CH_CR, 1'b0);
		offer_byte(qpd_pkg::CH_LF, 1'b0);
		offer_byte(qpd_pkg::CH_EQ, 1'b0);         // "=G1": three words from the last byte
		offer_byte(8'h47, 1'b0);
		offer_byte(8'h31, 1'b0);
		offer_byte(qpd_pkg::CH_EQ, 1'b0);         // "==41": escape restarts inside a broken one
		offer_byte(qpd_pkg::CH_EQ, 1'b0);
		offer_byte(8'h34, 1'b0);
		offer_byte(8'h31, 1'b0);
		offer_byte(qpd_pkg::CH_EQ, 1'b0);         // pending escape cleared by a new part
		offer_byte(8'h5A, 1'b1);
		wait_idle();

		// Limit of two hit in the middle of a three-word byte; the rest of the part is swallowed.
		write_limit(qpd_pkg::LIMIT_W'(2));
		offer_byte(qpd_pkg::CH_EQ, 1'b1);
		offer_byte(8'h47, 1'b0);
		offer_byte(8'h31, 1'b0);
		offer_byte(8'h42, 1'b0);
		offer_byte(8'h43, 1'b1);
		wait_idle();

		// Slow receiver, small limit, frequent new parts.
		write_limit(qpd_pkg::LIMIT_W'(5));
		random_phase(PHASE_BYTES, 1'b1);
		wait_idle();

		// Slow sender; the largest register value clamps to the part size.
		send_idle = 86;
		recv_idle = 16;
		write_limit({qpd_pkg::LIMIT_W{1'b1}});
		random_phase(PHASE_BYTES, 1'b1);
		wait_idle();

		// Full rate, unlimited; open with a long receiver hold-off so the input stalls.
		send_idle = 0;
		recv_idle = 0;
		write_limit('0);
		stall_tag++;
		random_phase(PHASE_BYTES, 1'b1);
		wait_idle();

		// A short unlimited part, then a limit lowered below its count swallows a byte.
		offer_byte(8'h61, 1'b1);
		repeat (SHORT_PART)
			offer_byte(8'h62, 1'b0);
		wait_idle();
		write_limit(qpd_pkg::LIMIT_W'(3));
		offer_byte(8'h63, 1'b0);
		wait_idle();
		write_limit(17'h10000);
		offer_byte(8'h7A, 1'b1);
		offer_byte(8'h79, 1'b0);
		wait_idle();
		write_limit(qpd_pkg::LIMIT_W'(1));
		offer_byte(8'h71, 1'b1);
		offer_byte(8'h72, 1'b0);
		wait_idle();
		write_limit('0);
		offer_byte(8'h5A, 1'b1);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
